// ----- src/arfp_pkg.sv -----
`default_nettype none

package arfp_pkg;

	localparam int unsigned DigitSlotsDefault = 4;
	localparam int unsigned DecodeDigits      = 4;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned DistW  = 16;
	localparam int unsigned LenW   = 4;
	localparam int unsigned FailW  = 8;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;

	localparam logic [LenW-1:0]  LengthMax     = 4'd15;
	localparam logic [LenW-1:0]  LenFailClear  = 4'd6;
	localparam logic [FailW-1:0] FailMax       = 8'hFF;
	localparam logic [DistW-1:0] AsciiZero     = 16'h0030;

	localparam logic [ByteW-1:0] HeaderOneReset = 8'd2;
	localparam logic [ByteW-1:0] HeaderTwoReset = 8'd35;
	localparam logic [ByteW-1:0] TailReset      = 8'd3;
	localparam logic [FailW-1:0] FailLimitReset = 8'd3;
	localparam logic [DistW-1:0] ErrorDistReset = 16'd9999;

	typedef enum logic [2:0] {
		RegHeaderOne,
		RegHeaderTwo,
		RegTail,
		RegFailLimit,
		RegErrorDistance
	} arfp_reg_t;

	typedef struct packed {
		logic [ByteW-1:0] header_one_byte;
		logic [ByteW-1:0] header_two_byte;
		logic [ByteW-1:0] tail_byte;
		logic [FailW-1:0] fail_limit;
		logic [DistW-1:0] error_distance;
	} arfp_cfg_t;

	typedef struct packed {
		logic             op;
		logic [ByteW-1:0] rx_byte;
	} arfp_in_t;

	typedef struct packed {
		logic             distance_update;
		logic [DistW-1:0] distance;
		logic             trigger_request;
		logic             link_reinit;
	} arfp_out_t;

endpackage

`default_nettype wire

// ----- src/arfp_if.sv -----
`default_nettype none

interface arfp_in_if;
	logic                            valid;
	logic                            ready;
	logic                            op;
	logic [arfp_pkg::ByteW-1:0]      rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface arfp_out_if;
	logic                            valid;
	logic                            ready;
	logic                            distance_update;
	logic [arfp_pkg::DistW-1:0]      distance;
	logic                            trigger_request;
	logic                            link_reinit;

	modport source (output valid, output distance_update, output distance,
		output trigger_request, output link_reinit, input ready);
	modport sink   (input valid, input distance_update, input distance,
		input trigger_request, input link_reinit, output ready);
endinterface

`default_nettype wire

// ----- src/arfp_regs.sv -----
`default_nettype none

module arfp_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [arfp_pkg::AddrW-1:0]    paddr,
	input  wire logic [arfp_pkg::DataW-1:0]    pwdata,
	output logic      [arfp_pkg::DataW-1:0]    prdata,
	output arfp_pkg::arfp_cfg_t                cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;
	arfp_pkg::arfp_cfg_t cfg_q;

	// Registers sit on word boundaries; the low address bits select nothing.
	assign reg_idx = paddr[arfp_pkg::AddrW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_one_byte <= arfp_pkg::HeaderOneReset;
			cfg_q.header_two_byte <= arfp_pkg::HeaderTwoReset;
			cfg_q.tail_byte       <= arfp_pkg::TailReset;
			cfg_q.fail_limit      <= arfp_pkg::FailLimitReset;
			cfg_q.error_distance  <= arfp_pkg::ErrorDistReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				arfp_pkg::RegHeaderOne:     cfg_q.header_one_byte <= pwdata[arfp_pkg::ByteW-1:0];
				arfp_pkg::RegHeaderTwo:     cfg_q.header_two_byte <= pwdata[arfp_pkg::ByteW-1:0];
				arfp_pkg::RegTail:          cfg_q.tail_byte       <= pwdata[arfp_pkg::ByteW-1:0];
				arfp_pkg::RegFailLimit:     cfg_q.fail_limit      <= pwdata[arfp_pkg::FailW-1:0];
				arfp_pkg::RegErrorDistance: cfg_q.error_distance  <= pwdata[arfp_pkg::DistW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			arfp_pkg::RegHeaderOne:     prdata = 32'(cfg_q.header_one_byte);
			arfp_pkg::RegHeaderTwo:     prdata = 32'(cfg_q.header_two_byte);
			arfp_pkg::RegTail:          prdata = 32'(cfg_q.tail_byte);
			arfp_pkg::RegFailLimit:     prdata = 32'(cfg_q.fail_limit);
			arfp_pkg::RegErrorDistance: prdata = 32'(cfg_q.error_distance);
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/arfp_decode.sv -----
`default_nettype none

module arfp_decode (
	input  wire logic [arfp_pkg::ByteW-1:0] digit [arfp_pkg::DecodeDigits],
	input  wire logic [arfp_pkg::LenW-1:0]  length,
	input  wire logic [arfp_pkg::DistW-1:0] error_distance,
	output logic      [arfp_pkg::DistW-1:0] distance
);

	logic [arfp_pkg::DistW-1:0] d [arfp_pkg::DecodeDigits];

	// Each digit is its byte less ASCII zero; everything wraps at 16 bits.
	always_comb begin
		for (int i = 0; i < arfp_pkg::DecodeDigits; i++) begin
			d[i] = {8'h00, digit[i]} - arfp_pkg::AsciiZero;
		end
	end

	always_comb begin
		unique case (length)
			4'd4: distance = 16'(d[0] * 16'd1000) + 16'(d[1] * 16'd100)
				+ 16'(d[2] * 16'd10) + d[3];
			4'd3: distance = 16'(d[0] * 16'd100) + 16'(d[1] * 16'd10) + d[2];
			4'd2: distance = 16'(d[0] * 16'd10) + d[1];
			4'd1: distance = d[0];
			default: distance = error_distance;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/ascii_range_frame_parser_core.sv -----
`default_nettype none

// Channel  | Direction | Handshake      | Payload
// ---------+-----------+----------------+----------------------------------------------
// in       | sink      | valid / ready  | op, rx_byte
// out      | source    | valid / ready  | distance_update, distance, trigger_request,
//          |           |                | link_reinit
// APB      | slave     | psel / penable | five configuration registers, pready tied high
//
// One transfer in, one transfer out per item, one item per cycle sustained while out.ready stays high.
// Each item passes the input register, then the framing logic into the
// result register, where the phase, length and fail count update as well.
// Reset clears the control state and restores the register defaults; the
// digit store is not cleared since every slot read is written first.
// With out.ready low the result holds, one more item waits, then in.ready drops.

module ascii_range_frame_parser_core #(
	parameter int unsigned DIGIT_SLOTS = arfp_pkg::DigitSlotsDefault
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	arfp_in_if.sink                         in,
	arfp_out_if.source                      out,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [arfp_pkg::AddrW-1:0] paddr,
	input  wire logic [arfp_pkg::DataW-1:0] pwdata,
	output logic      [arfp_pkg::DataW-1:0] prdata,
	output logic                            pready
);

	localparam int unsigned SlotW = $clog2(DIGIT_SLOTS);

	typedef enum logic [1:0] {
		PhIdle,
		PhSync,
		PhPayload
	} phase_t;

	arfp_pkg::arfp_cfg_t cfg;

	// Input register.
	logic                        valid_s1;
	logic                        op_s1;
	logic [arfp_pkg::ByteW-1:0]  byte_s1;

	// Framing state.
	phase_t                      phase_q;
	logic [arfp_pkg::LenW-1:0]   len_q;
	logic [arfp_pkg::FailW-1:0]  fail_q;
	logic [arfp_pkg::ByteW-1:0]  digit_q [DIGIT_SLOTS];

	// Result register.
	logic                        out_valid_q;
	arfp_pkg::arfp_out_t         res_q;

	// Next-state and result logic.
	logic                        fire;
	logic                        in_take;
	phase_t                      phase_n;
	logic [arfp_pkg::LenW-1:0]   len_n;
	logic [arfp_pkg::FailW-1:0]  fail_n;
	logic [arfp_pkg::FailW-1:0]  fail_inc;
	logic                        store_en;
	arfp_pkg::arfp_out_t         res_n;
	logic [arfp_pkg::ByteW-1:0]  dec_digit [arfp_pkg::DecodeDigits];
	logic [arfp_pkg::DistW-1:0]  dec_distance;

	assign pready = 1'b1;

	arfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The item in the input register is processed when the result register
	// is empty or is being emptied in this cycle.
	assign fire     = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || fire;
	assign in_take  = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= in.op;
			byte_s1 <= in.rx_byte;
		end
	end

	// Only the first slots take part in a distance.
	always_comb begin
		for (int i = 0; i < arfp_pkg::DecodeDigits; i++) begin
			dec_digit[i] = digit_q[i];
		end
	end

	arfp_decode u_decode (
		.digit          (dec_digit),
		.length         (len_q),
		.error_distance (cfg.error_distance),
		.distance       (dec_distance)
	);

	assign fail_inc = (fail_q == arfp_pkg::FailMax) ? fail_q : fail_q + 8'd1;

	// Framing machine. A first header byte wins over every other match, and
	// a second header byte counts only while synced; in payload it is data unless it is also the tail.
	always_comb begin
		phase_n  = phase_q;
		len_n    = len_q;
		fail_n   = fail_q;
		store_en = 1'b0;
		res_n    = '0;
		if (!op_s1) begin
			priority if (byte_s1 == cfg.header_one_byte) begin
				phase_n = PhSync;
			end else if (phase_q == PhSync && byte_s1 == cfg.header_two_byte) begin
				phase_n = PhPayload;
				len_n   = '0;
			end else if (phase_q == PhPayload) begin
				if (byte_s1 == cfg.tail_byte) begin
					// A short frame proves the sensor is alive.
					if (len_q < arfp_pkg::LenFailClear) begin
						fail_n = '0;
					end
					res_n.distance_update = 1'b1;
					res_n.distance        = dec_distance;
				end else begin
					store_en = len_q < arfp_pkg::LenW'(DIGIT_SLOTS);
					if (len_q != arfp_pkg::LengthMax) begin
						len_n = len_q + 4'd1;
					end
				end
			end
		end else begin
			// Poll timeout: always ask for a trigger; past the limit, also
			// reinitialize the link and report the error distance.
			res_n.trigger_request = 1'b1;
			fail_n                = fail_inc;
			if (fail_inc > cfg.fail_limit) begin
				res_n.link_reinit     = 1'b1;
				res_n.distance_update = 1'b1;
				res_n.distance        = cfg.error_distance;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			len_q   <= '0;
			fail_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			fail_q  <= fail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_en) begin
			digit_q[len_q[SlotW-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

	assign out.valid           = out_valid_q;
	assign out.distance_update = res_q.distance_update;
	assign out.distance        = res_q.distance;
	assign out.trigger_request = res_q.trigger_request;
	assign out.link_reinit     = res_q.link_reinit;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import arfp_pkg::*;

	// The limit leaves a wide margin over the length of the whole run.
	localparam int unsigned CycleLimit   = 200000;
	// Spare cycles after draining cover the input and result registers of the core.
	localparam int unsigned DrainCycles  = 4;
	// A single long receiver hold-off, started once this many results have arrived.
	localparam int unsigned HoldCycles   = 300;
	localparam int unsigned HoldAtResult = 60;
	// Rough percentage of the time in which each side stays idle.
	localparam int unsigned IdlePercent  = 20;
	localparam int unsigned SlotW        = $clog2(DigitSlotsDefault);

	typedef enum logic [1:0] {
		PhaseIdle,
		PhaseSync,
		PhasePayload
	} frame_phase_t;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	arfp_in_if  byte_ch ();
	arfp_out_if result_ch ();

	ascii_range_frame_parser_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in      (byte_ch),
		.out     (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// Items waiting to be offered on the byte channel, and the results that
	// the accepted items are due to produce, oldest first.
	arfp_in_t  byte_backlog [$];
	arfp_out_t due_results [$];

	int unsigned queued_items   = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	// When set, neither side inserts random idle cycles.
	bit          steady         = 1'b0;

	// Shadow of the configuration registers and of the framing state. The
	// configuration copy is updated at the clock edge that writes the register.
	arfp_cfg_t        cfg_now;
	frame_phase_t     phase_now  = PhaseIdle;
	logic [LenW-1:0]  length_now = '0;
	logic [ByteW-1:0] digit_bytes [DigitSlotsDefault];
	logic [FailW-1:0] fails_now  = '0;

	// Converts the collected payload into a distance. Each digit is the byte
	// minus ASCII zero in 16 bits, and the weighted sum wraps in 16 bits, so
	// non-digit bytes give wrapped or out-of-range values rather than an error.
	function automatic logic [DistW-1:0] frame_distance();
		logic [DistW-1:0] d0;
		logic [DistW-1:0] d1;
		logic [DistW-1:0] d2;
		logic [DistW-1:0] d3;
		logic [DistW-1:0] sum;
		d0 = {8'h00, digit_bytes[0]} - AsciiZero;
		d1 = {8'h00, digit_bytes[1]} - AsciiZero;
		d2 = {8'h00, digit_bytes[2]} - AsciiZero;
		d3 = {8'h00, digit_bytes[3]} - AsciiZero;
		case (length_now)
			4'd4: begin
				sum = d0 * 16'd1000 + d1 * 16'd100 + d2 * 16'd10 + d3;
			end
			4'd3: begin
				sum = d0 * 16'd100 + d1 * 16'd10 + d2;
			end
			4'd2: begin
				sum = d0 * 16'd10 + d1;
			end
			4'd1: begin
				sum = d0;
			end
			default: begin
				// An empty frame or more digits than the decoder takes.
				sum = cfg_now.error_distance;
			end
		endcase
		return sum;
	endfunction

	// Advances the shadow framing state by one accepted item and returns the
	// result that the core must produce for it.
	function automatic arfp_out_t frame_step(arfp_in_t item);
		arfp_out_t res;
		res = '0;
		if (item.op == 1'b0) begin
			// The first header wins over every other match, in any phase.
			if (item.rx_byte == cfg_now.header_one_byte) begin
				phase_now = PhaseSync;
			end else if (phase_now == PhaseSync && item.rx_byte == cfg_now.header_two_byte) begin
				phase_now  = PhasePayload;
				length_now = '0;
				for (int k = 0; k < DigitSlotsDefault; k++) begin
					digit_bytes[k] = '0;
				end
			end else if (phase_now == PhasePayload) begin
				if (item.rx_byte == cfg_now.tail_byte) begin
					// A plausible frame shows the sensor is alive again. The
					// phase stays in payload, so later bytes keep collecting.
					if (length_now < LenFailClear) begin
						fails_now = '0;
					end
					res.distance_update = 1'b1;
					res.distance        = frame_distance();
				end else begin
					// Bytes past the store are counted but dropped, and the
					// count itself saturates.
					if (length_now < DigitSlotsDefault) begin
						digit_bytes[length_now[SlotW-1:0]] = item.rx_byte;
					end
					if (length_now != LengthMax) begin
						length_now = length_now + 1'b1;
					end
				end
			end
			// Anything else while idle or synced is ignored.
		end else begin
			// A poll timeout always asks for a new trigger; past the limit the
			// link is reset and the error distance is reported.
			res.trigger_request = 1'b1;
			if (fails_now != FailMax) begin
				fails_now = fails_now + 1'b1;
			end
			if (fails_now > cfg_now.fail_limit) begin
				res.link_reinit     = 1'b1;
				res.distance_update = 1'b1;
				res.distance        = cfg_now.error_distance;
			end
		end
		return res;
	endfunction

	// Byte channel driver. A new item is put up only when the slot is free,
	// that is when nothing is offered or the offered item is taken at this
	// edge; the accepted item is run through the shadow parser right here.
	always @(posedge clk) begin : drive_bytes
		arfp_in_t taken;
		arfp_in_t next_item;
		if (!arst_n) begin
			byte_ch.valid   <= 1'b0;
			byte_ch.op      <= 1'b0;
			byte_ch.rx_byte <= '0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (byte_ch.valid) begin
				taken.op      = byte_ch.op;
				taken.rx_byte = byte_ch.rx_byte;
				due_results.push_back(frame_step(taken));
			end
			if (byte_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePercent)) begin
				next_item       = byte_backlog.pop_front();
				byte_ch.valid   <= 1'b1;
				byte_ch.op      <= next_item.op;
				byte_ch.rx_byte <= next_item.rx_byte;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// Result channel monitor. Every transfer is checked against the oldest
	// expected result. The ready side idles at random, and once in the run
	// it holds off for a long stretch so that the core fills and stalls its
	// input while the driver keeps offering items.
	always @(posedge clk) begin : check_results
		arfp_out_t   want;
		int unsigned hold_left;
		bit          hold_done;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$error("result transfer with none expected: distance %0d", result_ch.distance);
					mismatch_count++;
				end else begin
					want = due_results.pop_front();
					if (result_ch.distance_update !== want.distance_update) begin
						$error("distance_update: expected %0d, actual %0d",
							want.distance_update, result_ch.distance_update);
						mismatch_count++;
					end
					if (result_ch.distance !== want.distance) begin
						$error("distance: expected %0d, actual %0d",
							want.distance, result_ch.distance);
						mismatch_count++;
					end
					if (result_ch.trigger_request !== want.trigger_request) begin
						$error("trigger_request: expected %0d, actual %0d",
							want.trigger_request, result_ch.trigger_request);
						mismatch_count++;
					end
					if (result_ch.link_reinit !== want.link_reinit) begin
						$error("link_reinit: expected %0d, actual %0d",
							want.link_reinit, result_ch.link_reinit);
						mismatch_count++;
					end
				end
			end
			if (!hold_done && results_seen >= HoldAtResult) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || $urandom_range(0, 99) >= IdlePercent;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// One APB write: setup cycle, then access cycle until pready is seen.
	task automatic reg_write(arfp_reg_t idx, logic [DataW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			RegHeaderOne:     cfg_now.header_one_byte = value[ByteW-1:0];
			RegHeaderTwo:     cfg_now.header_two_byte = value[ByteW-1:0];
			RegTail:          cfg_now.tail_byte       = value[ByteW-1:0];
			RegFailLimit:     cfg_now.fail_limit      = value[FailW-1:0];
			RegErrorDistance: cfg_now.error_distance  = value[DistW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(arfp_cfg_t c);
		reg_write(RegHeaderOne, DataW'(c.header_one_byte));
		reg_write(RegHeaderTwo, DataW'(c.header_two_byte));
		reg_write(RegTail, DataW'(c.tail_byte));
		reg_write(RegFailLimit, DataW'(c.fail_limit));
		reg_write(RegErrorDistance, DataW'(c.error_distance));
	endtask

	function automatic arfp_cfg_t make_cfg(logic [ByteW-1:0] h1, logic [ByteW-1:0] h2,
			logic [ByteW-1:0] tail, logic [FailW-1:0] limit, logic [DistW-1:0] err);
		arfp_cfg_t c;
		c.header_one_byte = h1;
		c.header_two_byte = h2;
		c.tail_byte       = tail;
		c.fail_limit      = limit;
		c.error_distance  = err;
		return c;
	endfunction

	// Random setting with three distinct marker bytes, so that frames parse.
	function automatic arfp_cfg_t random_cfg();
		arfp_cfg_t c;
		c.header_one_byte = ByteW'($urandom_range(0, 255));
		do c.header_two_byte = ByteW'($urandom_range(0, 255));
		while (c.header_two_byte == c.header_one_byte);
		do c.tail_byte = ByteW'($urandom_range(0, 255));
		while (c.tail_byte == c.header_one_byte || c.tail_byte == c.header_two_byte);
		c.fail_limit     = FailW'($urandom_range(0, 5));
		c.error_distance = DistW'($urandom_range(0, 65535));
		return c;
	endfunction

	task automatic queue_item(logic op, logic [ByteW-1:0] value);
		arfp_in_t it;
		it.op      = op;
		it.rx_byte = value;
		byte_backlog.push_back(it);
		queued_items++;
	endtask

	// Mostly ASCII digits, sometimes any byte; never a byte that would end or
	// restart the frame under the current setting.
	function automatic logic [ByteW-1:0] payload_byte();
		logic [ByteW-1:0] b;
		do begin
			if ($urandom_range(0, 99) < 80) begin
				b = AsciiZero[ByteW-1:0] + ByteW'($urandom_range(0, 9));
			end else begin
				b = ByteW'($urandom_range(0, 255));
			end
		end while (b == cfg_now.header_one_byte || b == cfg_now.tail_byte);
		return b;
	endfunction

	// Most frames carry one to four digits; some are empty, slightly long, or
	// long enough to saturate the length counter.
	function automatic int frame_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 4);
		end else if (r < 80) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(5, 7);
		end
		return $urandom_range(8, 18);
	endfunction

	task automatic queue_frame(int len);
		queue_item(1'b0, cfg_now.header_one_byte);
		queue_item(1'b0, cfg_now.header_two_byte);
		repeat (len) queue_item(1'b0, payload_byte());
		queue_item(1'b0, cfg_now.tail_byte);
	endtask

	// Unstructured traffic drawn from the marker bytes, digits, any byte and
	// timeouts, so that collisions between the markers get exercised.
	task automatic queue_noise(int n);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: queue_item(1'b0, cfg_now.header_one_byte);
				1: queue_item(1'b0, cfg_now.header_two_byte);
				2: queue_item(1'b0, cfg_now.tail_byte);
				3: queue_item(1'b0, AsciiZero[ByteW-1:0] + ByteW'($urandom_range(0, 9)));
				4: queue_item(1'b0, ByteW'($urandom_range(0, 255)));
				default: queue_item(1'b1, ByteW'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// Random traffic that is mostly well-formed frames with random content,
	// mixed with frames that keep collecting after the tail, frames cut off
	// before the tail, runs of timeouts and plain noise.
	task automatic random_phase(int n);
		int unsigned start;
		int          r;
		start = queued_items;
		while (queued_items - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				queue_frame(frame_length());
			end else if (r < 70) begin
				queue_frame(frame_length());
				repeat ($urandom_range(1, 3)) queue_item(1'b0, payload_byte());
				queue_item(1'b0, cfg_now.tail_byte);
			end else if (r < 80) begin
				queue_item(1'b0, cfg_now.header_one_byte);
				if ($urandom_range(0, 1) == 1) begin
					queue_item(1'b0, cfg_now.header_two_byte);
				end
				repeat ($urandom_range(0, 3)) queue_item(1'b0, payload_byte());
			end else if (r < 90) begin
				repeat ($urandom_range(1, 4)) queue_item(1'b1, ByteW'($urandom_range(0, 255)));
			end else begin
				queue_noise($urandom_range(1, 3));
			end
		end
	endtask

	// Holds the sender back until every queued item has been taken and every
	// expected result has arrived, then lets the pipeline settle.
	task automatic drain();
		while (byte_backlog.size() != 0 || byte_ch.valid || due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin : stimulus
		arfp_cfg_t c;

		// The configuration port is at a known level before the first edge.
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;

		cfg_now    = make_cfg(HeaderOneReset, HeaderTwoReset, TailReset, FailLimitReset,
			ErrorDistReset);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset setting. Four timeouts push the fail
		// count over the default limit of three.
		queue_item(1'b1, 8'hFF);
		queue_item(1'b1, 8'h00);
		queue_item(1'b1, 8'hAA);
		queue_item(1'b1, 8'h55);
		// While idle, stray bytes, a tail and a second header are ignored.
		queue_item(1'b0, 8'h00);
		queue_item(1'b0, TailReset);
		queue_item(1'b0, HeaderTwoReset);
		// Sync, a stray byte that keeps sync, then a full four-digit frame.
		queue_item(1'b0, HeaderOneReset);
		queue_item(1'b0, 8'hFF);
		queue_item(1'b0, HeaderTwoReset);
		queue_item(1'b0, "9");
		queue_item(1'b0, "0");
		queue_item(1'b0, "0");
		queue_item(1'b0, "1");
		queue_item(1'b0, TailReset);
		// A second tail decodes the same digits again; a fifth digit then
		// makes the frame too long to decode.
		queue_item(1'b0, TailReset);
		queue_item(1'b0, "5");
		queue_item(1'b0, TailReset);
		// A header inside the payload restarts the frame; an empty frame.
		queue_item(1'b0, HeaderOneReset);
		queue_item(1'b0, HeaderTwoReset);
		queue_item(1'b0, TailReset);
		// The second header value and a zero byte are stored as payload and
		// decode to a wrapped value.
		queue_item(1'b0, HeaderTwoReset);
		queue_item(1'b0, 8'h00);
		queue_item(1'b0, TailReset);
		queue_item(1'b1, 8'h3C);
		drain();

		// Random setting; the long receiver hold-off falls in this stretch.
		apply_cfg(random_cfg());
		random_phase(100);
		drain();

		// Low extremes, with no idling on either side: every timeout
		// reinitializes the link since the limit is zero.
		steady = 1'b1;
		apply_cfg(make_cfg(8'h00, 8'hFF, 8'h80, 8'h00, 16'h0000));
		random_phase(70);
		drain();
		steady = 1'b0;

		// High extremes: the limit is never exceeded.
		apply_cfg(make_cfg(8'hFF, 8'h00, 8'h01, 8'hFF, 16'hFFFF));
		random_phase(60);
		drain();

		// All three marker bytes equal: the first header always wins.
		apply_cfg(make_cfg(8'h55, 8'h55, 8'h55, 8'h01, 16'd1234));
		queue_noise(10);
		drain();

		// Second header equal to the tail: inside a frame it acts as a tail.
		apply_cfg(make_cfg(8'h10, 8'h20, 8'h20, 8'h02, 16'd4321));
		queue_frame(2);
		queue_noise(10);
		drain();

		// A long run of timeouts drives the fail count into saturation; with
		// a limit of 254 the reinit request only appears at the top.
		c            = random_cfg();
		c.fail_limit = 8'd254;
		apply_cfg(c);
		repeat (262) queue_item(1'b1, ByteW'($urandom_range(0, 255)));
		random_phase(20);
		drain();

		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/arfp_pkg.sv
src/arfp_if.sv
src/arfp_regs.sv
src/arfp_decode.sv
src/ascii_range_frame_parser_core.sv
dv/testbench.sv
